// ===== sv/bclb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bclb_pkg
// Shared types, widths and fixed-point helpers for the bicubic basis block.
// ----------------------------------------------------------------------------
package bclb_pkg;

    localparam int COORD_W  = 16;
    localparam int OUT_W    = 20;
    localparam int NODE_W   = 4;
    localparam int INT_FRAC = 28;
    localparam int INT_W    = 31;
    localparam int FAC_W    = 34;
    localparam int PROD_W   = 2 * FAC_W;
    localparam int SPLIT_W  = 17;

    typedef logic signed [INT_W-1:0] int_t;
    typedef logic signed [FAC_W-1:0] fac_t;
    typedef fac_t [3:0]              fac_set_t;

    localparam int_t SQRT3_Q = 31'sd464943848;
    localparam int_t ONE_Q   = 31'sd268435456;

    localparam logic [NODE_W-1:0]       NODE_LAST = 4'd15;
    localparam logic signed [OUT_W-1:0] OUT_MAX   = 20'sh7FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN   = 20'sh80000;

    localparam logic signed [2*INT_W-1:0] QMUL_HALF = (2 * INT_W)'(1) << (INT_FRAC - 1);

    // stage load enables of the coordinate pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } axis_adv_t;

    // stage load enables of the product pipeline
    typedef struct packed {
        logic p2;
        logic p3;
        logic p4;
    } mul_adv_t;

    // Q.28 product, round to nearest with ties up
    function automatic int_t qmul(input int_t a, input int_t b);
        logic signed [2*INT_W-1:0] p;
        logic signed [2*INT_W-1:0] sh;
        p  = a * b;
        p  = p + QMUL_HALF;
        sh = p >>> INT_FRAC;
        return sh[INT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/bclb_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bclb_axis
// Four-stage powers pipeline for one coordinate, then the cubic factor sums.
// ----------------------------------------------------------------------------
module bclb_axis #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                clk,
    input  bclb_pkg::axis_adv_t                 adv,
    input  logic signed [bclb_pkg::COORD_W-1:0] coord,
    output bclb_pkg::fac_set_t                  num,
    output bclb_pkg::fac_set_t                  der
);
    import bclb_pkg::*;

    localparam int WIDE_W = 48;
    localparam int UP_SH  = (FRAC_BITS <= INT_FRAC) ? INT_FRAC - FRAC_BITS : 0;
    localparam int DN_SH  = (FRAC_BITS > INT_FRAC) ? FRAC_BITS - INT_FRAC : 0;
    localparam logic signed [WIDE_W-1:0] LIM     = WIDE_W'(1) << FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] DN_HALF = (WIDE_W'(1) << DN_SH) >> 1;

    localparam fac_t K3 = 34'sd3;
    localparam fac_t K6 = 34'sd6;
    localparam fac_t K9 = 34'sd9;

    logic signed [WIDE_W-1:0] v_sat;
    logic signed [WIDE_W-1:0] v_q;
    int_t x_new;

    int_t x1_reg;
    int_t x2_reg, sq2_reg, sx2_reg;
    int_t x3_reg, sq3_reg, sx3_reg, cb3_reg, ssq3_reg;
    int_t x4_reg, sq4_reg, sx4_reg, cb4_reg, ssq4_reg, scb4_reg;

    fac_t fx, fsq, fsx, fcb, fssq, fscb, fone, fs;

    // clamp to [-1, 1] and move into Q.28
    always_comb
    begin
        v_sat = {{(WIDE_W - COORD_W){coord[COORD_W-1]}}, coord};
        if (v_sat > LIM)
        begin
            v_sat = LIM;
        end
        if (v_sat < -LIM)
        begin
            v_sat = -LIM;
        end
        if (FRAC_BITS <= INT_FRAC)
        begin
            v_q = v_sat <<< UP_SH;
        end
        else
        begin
            v_q = (v_sat + DN_HALF) >>> DN_SH;
        end
        x_new = v_q[INT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            x1_reg <= x_new;
        end
        if (adv.s2)
        begin
            x2_reg  <= x1_reg;
            sq2_reg <= qmul(x1_reg, x1_reg);
            sx2_reg <= qmul(SQRT3_Q, x1_reg);
        end
        if (adv.s3)
        begin
            x3_reg   <= x2_reg;
            sq3_reg  <= sq2_reg;
            sx3_reg  <= sx2_reg;
            cb3_reg  <= qmul(sq2_reg, x2_reg);
            ssq3_reg <= qmul(SQRT3_Q, sq2_reg);
        end
        if (adv.s4)
        begin
            x4_reg   <= x3_reg;
            sq4_reg  <= sq3_reg;
            sx4_reg  <= sx3_reg;
            cb4_reg  <= cb3_reg;
            ssq4_reg <= ssq3_reg;
            scb4_reg <= qmul(SQRT3_Q, cb3_reg);
        end
    end

    // four times the 1-d factors and their derivatives
    always_comb
    begin
        fx   = FAC_W'(x4_reg);
        fsq  = FAC_W'(sq4_reg);
        fsx  = FAC_W'(sx4_reg);
        fcb  = FAC_W'(cb4_reg);
        fssq = FAC_W'(ssq4_reg);
        fscb = FAC_W'(scb4_reg);
        fone = FAC_W'(ONE_Q);
        fs   = FAC_W'(SQRT3_Q);

        num[0] = K3 * fsq - K3 * fcb + fx - fone;
        num[1] = K3 * fone - K3 * fsx - K3 * fsq + K3 * fscb;
        num[2] = K3 * fone + K3 * fsx - K3 * fsq - K3 * fscb;
        num[3] = K3 * fcb + K3 * fsq - fx - fone;

        der[0] = K6 * fx - K9 * fsq + fone;
        der[1] = K9 * fssq - K6 * fx - K3 * fs;
        der[2] = K3 * fs - K9 * fssq - K6 * fx;
        der[3] = K9 * fsq + K6 * fx - fone;
    end

endmodule
`default_nettype wire

// ===== sv/bclb_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bclb_mul
// Split 34x34 product over partial-product, combine and round/saturate stages.
// ----------------------------------------------------------------------------
module bclb_mul #(
    parameter int FRAC_BITS = 14
) (
    input  logic                              clk,
    input  bclb_pkg::mul_adv_t                adv,
    input  bclb_pkg::fac_t                    a,
    input  bclb_pkg::fac_t                    b,
    output logic signed [bclb_pkg::OUT_W-1:0] res
);
    import bclb_pkg::*;

    localparam int SH   = 2 * INT_FRAC + 4 - FRAC_BITS;
    localparam int HI_W = FAC_W - SPLIT_W;
    localparam int LO_P = FAC_W + SPLIT_W + 1;
    localparam int HI_P = FAC_W + HI_W;
    localparam logic signed [PROD_W-1:0] HALF  = PROD_W'(1) << (SH - 1);
    localparam logic signed [PROD_W-1:0] MAX_W = PROD_W'(OUT_MAX);
    localparam logic signed [PROD_W-1:0] MIN_W = PROD_W'(OUT_MIN);

    logic signed [SPLIT_W:0]   b_lo;
    logic signed [HI_W-1:0]    b_hi;
    logic signed [LO_P-1:0]    plo;
    logic signed [HI_P-1:0]    phi;
    logic signed [LO_P-1:0]    plo_reg;
    logic signed [HI_P-1:0]    phi_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [OUT_W-1:0]   sat;
    logic signed [OUT_W-1:0]   res_reg;

    always_comb
    begin
        b_lo = $signed({1'b0, b[SPLIT_W-1:0]});
        b_hi = $signed(b[FAC_W-1:SPLIT_W]);
        plo  = a * b_lo;
        phi  = a * b_hi;
    end

    always_comb
    begin
        rounded = (prod_reg + HALF) >>> SH;
        if (rounded > MAX_W)
        begin
            sat = OUT_MAX;
        end
        else if (rounded < MIN_W)
        begin
            sat = OUT_MIN;
        end
        else
        begin
            sat = rounded[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.p2)
        begin
            plo_reg <= plo;
            phi_reg <= phi;
        end
        if (adv.p3)
        begin
            prod_reg <= (PROD_W'(phi_reg) <<< SPLIT_W) + PROD_W'(plo_reg);
        end
        if (adv.p4)
        begin
            res_reg <= sat;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// ===== sv/bicubic_lagrange_basis_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bicubic_lagrange_basis_eval
// Bicubic Lagrange shape functions and gradients at one reference point.
// ----------------------------------------------------------------------------
// usage
//   point channel : point_valid / point_stall carry (ksi_coord, eta_coord),
//                   signed Q1.FRAC_BITS, clamped to [-1, 1] on entry
//   result channel: result_valid / result_stall carry 16 transfers per point,
//                   node_index 0..15 in row-major order (4*eta + ksi), with
//                   basis_value, grad_ksi, grad_eta in Q5.FRAC_BITS saturated
//                   and last_node set on the sixteenth
//   throughput    : one result per cycle while result_stall is low; set by
//                   the factor hold register, which issues one node per cycle
//                   into the three product pipelines when they can advance
//   coordinate front end takes four stages and can queue up to four points
//   reset         : all valid bits and the node counter clear, nothing pending
//   stall         : result_stall freezes the output register; the pipeline
//                   keeps filling its empty stages and then asserts point_stall
// ----------------------------------------------------------------------------
module bicubic_lagrange_basis_eval #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_stall,
    input  logic signed [bclb_pkg::COORD_W-1:0] ksi_coord,
    input  logic signed [bclb_pkg::COORD_W-1:0] eta_coord,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [bclb_pkg::NODE_W-1:0]         node_index,
    output logic signed [bclb_pkg::OUT_W-1:0]   basis_value,
    output logic signed [bclb_pkg::OUT_W-1:0]   grad_ksi,
    output logic signed [bclb_pkg::OUT_W-1:0]   grad_eta,
    output logic                                last_node
);
    import bclb_pkg::*;

    // valid bits of the coordinate front end
    logic f1_vld_reg, f1_vld_next;
    logic f2_vld_reg, f2_vld_next;
    logic f3_vld_reg, f3_vld_next;
    logic f4_vld_reg, f4_vld_next;

    // factor hold register and node counter
    logic              hold_vld_reg, hold_vld_next;
    logic [NODE_W-1:0] cnt_reg, cnt_next;
    fac_set_t          nk_reg, dk_reg, ne_reg, de_reg;

    // valid bits of the product pipeline
    logic p1_vld_reg, p1_vld_next;
    logic p2_vld_reg, p2_vld_next;
    logic p3_vld_reg, p3_vld_next;
    logic p4_vld_reg, p4_vld_next;

    // selected factors and node tags moving with the products
    fac_t              nk1_reg, dk1_reg, ne1_reg, de1_reg;
    logic [NODE_W-1:0] node1_reg, node2_reg, node3_reg, node4_reg;
    logic              last1_reg, last2_reg, last3_reg, last4_reg;

    // per-stage load enables
    logic rdy_f1, rdy_f2, rdy_f3, rdy_f4, rdy_hold;
    logic rdy_p1, rdy_p2, rdy_p3, rdy_p4;
    logic emit, release_hold;

    axis_adv_t axis_adv;
    mul_adv_t  mul_adv;
    fac_set_t  ksi_num, ksi_der, eta_num, eta_der;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        rdy_p4       = !p4_vld_reg || !result_stall;
        rdy_p3       = !p3_vld_reg || rdy_p4;
        rdy_p2       = !p2_vld_reg || rdy_p3;
        rdy_p1       = !p1_vld_reg || rdy_p2;
        emit         = hold_vld_reg && rdy_p1;
        release_hold = emit && (cnt_reg == NODE_LAST);
        rdy_hold     = !hold_vld_reg || release_hold;
        rdy_f4       = !f4_vld_reg || rdy_hold;
        rdy_f3       = !f3_vld_reg || rdy_f4;
        rdy_f2       = !f2_vld_reg || rdy_f3;
        rdy_f1       = !f1_vld_reg || rdy_f2;
    end

    assign point_stall = !rdy_f1;
    assign axis_adv    = '{s1: rdy_f1, s2: rdy_f2, s3: rdy_f3, s4: rdy_f4};
    assign mul_adv     = '{p2: rdy_p2, p3: rdy_p3, p4: rdy_p4};

    always_comb
    begin
        f1_vld_next   = rdy_f1 ? point_valid : f1_vld_reg;
        f2_vld_next   = rdy_f2 ? f1_vld_reg : f2_vld_reg;
        f3_vld_next   = rdy_f3 ? f2_vld_reg : f3_vld_reg;
        f4_vld_next   = rdy_f4 ? f3_vld_reg : f4_vld_reg;
        hold_vld_next = rdy_hold ? f4_vld_reg : hold_vld_reg;
        // counter wraps to zero on the sixteenth node
        cnt_next      = emit ? cnt_reg + NODE_W'(1) : cnt_reg;
        p1_vld_next   = rdy_p1 ? hold_vld_reg : p1_vld_reg;
        p2_vld_next   = rdy_p2 ? p1_vld_reg : p2_vld_reg;
        p3_vld_next   = rdy_p3 ? p2_vld_reg : p3_vld_reg;
        p4_vld_next   = rdy_p4 ? p3_vld_reg : p4_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg   <= 1'b0;
            f2_vld_reg   <= 1'b0;
            f3_vld_reg   <= 1'b0;
            f4_vld_reg   <= 1'b0;
            hold_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            p3_vld_reg   <= 1'b0;
            p4_vld_reg   <= 1'b0;
        end
        else
        begin
            f1_vld_reg   <= f1_vld_next;
            f2_vld_reg   <= f2_vld_next;
            f3_vld_reg   <= f3_vld_next;
            f4_vld_reg   <= f4_vld_next;
            hold_vld_reg <= hold_vld_next;
            cnt_reg      <= cnt_next;
            p1_vld_reg   <= p1_vld_next;
            p2_vld_reg   <= p2_vld_next;
            p3_vld_reg   <= p3_vld_next;
            p4_vld_reg   <= p4_vld_next;
        end
    end

    // one coordinate pipeline per axis
    bclb_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_ksi (
        .clk   (clk),
        .adv   (axis_adv),
        .coord (ksi_coord),
        .num   (ksi_num),
        .der   (ksi_der)
    );

    bclb_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_eta (
        .clk   (clk),
        .adv   (axis_adv),
        .coord (eta_coord),
        .num   (eta_num),
        .der   (eta_der)
    );

    // hold the factor sets of one point, pick the pair for the current node
    always_ff @(posedge clk)
    begin
        if (rdy_hold)
        begin
            nk_reg <= ksi_num;
            dk_reg <= ksi_der;
            ne_reg <= eta_num;
            de_reg <= eta_der;
        end
        if (rdy_p1)
        begin
            nk1_reg   <= nk_reg[cnt_reg[1:0]];
            dk1_reg   <= dk_reg[cnt_reg[1:0]];
            ne1_reg   <= ne_reg[cnt_reg[3:2]];
            de1_reg   <= de_reg[cnt_reg[3:2]];
            node1_reg <= cnt_reg;
            last1_reg <= (cnt_reg == NODE_LAST);
        end
        if (rdy_p2)
        begin
            node2_reg <= node1_reg;
            last2_reg <= last1_reg;
        end
        if (rdy_p3)
        begin
            node3_reg <= node2_reg;
            last3_reg <= last2_reg;
        end
        if (rdy_p4)
        begin
            node4_reg <= node3_reg;
            last4_reg <= last3_reg;
        end
    end

    // value, d/dksi and d/deta products
    bclb_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_value (
        .clk (clk),
        .adv (mul_adv),
        .a   (nk1_reg),
        .b   (ne1_reg),
        .res (basis_value)
    );

    bclb_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_gksi (
        .clk (clk),
        .adv (mul_adv),
        .a   (dk1_reg),
        .b   (ne1_reg),
        .res (grad_ksi)
    );

    bclb_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_geta (
        .clk (clk),
        .adv (mul_adv),
        .a   (nk1_reg),
        .b   (de1_reg),
        .res (grad_eta)
    );

    assign result_valid = p4_vld_reg;
    assign node_index   = node4_reg;
    assign last_node    = last4_reg;

`ifndef SYNTHESIS
    // the factor set stays until its sixteenth node has been issued
    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_vld_reg && !release_hold) |=> hold_vld_reg)
        else $error("factor hold dropped before last node");

    // a run in progress always has its factors held
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> hold_vld_reg)
        else $error("node counter running without held factors");

    // the end marker travels with node fifteen
    a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_node) |-> (node_index == NODE_LAST))
        else $error("last_node on wrong node");
`endif

endmodule
`default_nettype wire
